// ===== rtl/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared constants and types for the channel binding table.
// ----------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int OP_W    = 3;
    localparam int IFACE_W = 32;
    localparam int CHAN_W  = 8;
    localparam int ENTRY_W = IFACE_W + CHAN_W;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN      = 3'd0,
        OP_CLOSE     = 3'd1,
        OP_IF_LOOKUP = 3'd2,
        OP_CH_LOOKUP = 3'd3,
        OP_REMOVE    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic               we;
        logic [SLOT_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [SLOT_W-1:0]  raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/cbt_req_if.sv =====
// ----------------------------------------------------------------------------
// cbt_req_if
// Request channel: one table operation per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbt_req_if
    import cbt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [IFACE_W-1:0] iface_id;
    logic [CHAN_W-1:0]  chan;

    modport source (output valid, output op, output iface_id, output chan, input ready);
    modport sink   (input valid, input op, input iface_id, input chan, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cbt_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbt_rsp_if
    import cbt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [CHAN_W-1:0]  chan_out;
    logic [IFACE_W-1:0] iface_out;

    modport source (output valid, output ok, output chan_out, output iface_out, input ready);
    modport sink   (input valid, input ok, input chan_out, input iface_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbt_ram.sv =====
// ----------------------------------------------------------------------------
// cbt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 40,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbt_ctrl
// Scan sequencer: walks the slot RAM one entry a cycle, keeps valid marks
// and the channel counter, and holds the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_ctrl
    import cbt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    cbt_req_if.sink                 req,
    cbt_rsp_if.source               rsp,
    output mem_req_t                mem_req,
    input  wire logic [ENTRY_W-1:0] mem_rdata
);

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [IFACE_W-1:0]  id_reg, id_next;
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [SLOT_W-1:0]   rd_slot_reg, rd_slot_next;
    logic [CHAN_W-1:0]   cand_reg, cand_next;
    logic [CHAN_W-1:0]   next_chan_reg, next_chan_next;
    logic                free_found_reg, free_found_next;
    logic [SLOT_W-1:0]   free_slot_reg, free_slot_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic                res_ok_reg, res_ok_next;
    logic [CHAN_W-1:0]   res_chan_reg, res_chan_next;
    logic [IFACE_W-1:0]  res_iface_reg, res_iface_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg, out_ok_next;
    logic [CHAN_W-1:0]   out_chan_reg, out_chan_next;
    logic [IFACE_W-1:0]  out_iface_reg, out_iface_next;

    logic [IFACE_W-1:0]  rd_iface;
    logic [CHAN_W-1:0]   rd_chan;
    logic                rd_valid;
    logic                key_match;
    logic                hit;
    logic                scan_done;

    assign rd_iface  = mem_rdata[ENTRY_W-1:CHAN_W];
    assign rd_chan   = mem_rdata[CHAN_W-1:0];
    assign rd_valid  = valid_reg[rd_slot_reg];
    assign scan_done = !pend_reg && (idx_reg == CNT_W'(SLOTS));

    always_comb
    begin
        case (op_t'(op_reg))
            OP_OPEN:      key_match = (rd_chan == cand_reg);
            OP_CLOSE:     key_match = (rd_chan == chan_reg);
            OP_IF_LOOKUP: key_match = (rd_chan == chan_reg);
            OP_CH_LOOKUP: key_match = (rd_iface == id_reg);
            OP_REMOVE:    key_match = (rd_iface == id_reg);
            default:      key_match = 1'b0;
        endcase
    end

    assign hit = pend_reg && rd_valid && key_match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            next_chan_reg <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            next_chan_reg <= next_chan_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        chan_reg       <= chan_next;
        idx_reg        <= idx_next;
        rd_slot_reg    <= rd_slot_next;
        cand_reg       <= cand_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        res_ok_reg     <= res_ok_next;
        res_chan_reg   <= res_chan_next;
        res_iface_reg  <= res_iface_next;
        out_ok_reg     <= out_ok_next;
        out_chan_reg   <= out_chan_next;
        out_iface_reg  <= out_iface_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        chan_next       = chan_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        rd_slot_next    = rd_slot_reg;
        cand_next       = cand_reg;
        next_chan_next  = next_chan_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        valid_next      = valid_reg;
        res_ok_next     = res_ok_reg;
        res_chan_next   = res_chan_reg;
        res_iface_next  = res_iface_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_ok_next     = out_ok_reg;
        out_chan_next   = out_chan_reg;
        out_iface_next  = out_iface_reg;
        mem_req         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.op;
                    id_next         = req.iface_id;
                    chan_next       = req.chan;
                    idx_next        = '0;
                    cand_next       = next_chan_reg;
                    free_found_next = 1'b0;
                    res_ok_next     = 1'b0;
                    res_chan_next   = '0;
                    res_iface_next  = '0;
                    // unknown ops answer zeros without touching the table
                    if (req.op > OP_W'(OP_REMOVE))
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (idx_reg < CNT_W'(SLOTS))
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg[SLOT_W-1:0];
                    pend_next     = 1'b1;
                    rd_slot_next  = idx_reg[SLOT_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end

                if (op_t'(op_reg) == OP_OPEN && pend_reg && !rd_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_slot_next  = rd_slot_reg;
                end

                if (hit)
                begin
                    case (op_t'(op_reg))
                        OP_OPEN:
                        begin
                            // candidate in use: try the next channel from slot 0
                            cand_next   = cand_reg + 1'b1;
                            idx_next    = '0;
                            pend_next   = 1'b0;
                            mem_req.re  = 1'b0;
                        end
                        OP_CLOSE:
                        begin
                            valid_next[rd_slot_reg] = 1'b0;
                            state_next              = ST_RESP;
                        end
                        OP_IF_LOOKUP:
                        begin
                            res_ok_next    = 1'b1;
                            res_iface_next = rd_iface;
                            state_next     = ST_RESP;
                        end
                        OP_CH_LOOKUP:
                        begin
                            res_ok_next   = 1'b1;
                            res_chan_next = rd_chan;
                            state_next    = ST_RESP;
                        end
                        OP_REMOVE:
                        begin
                            valid_next[rd_slot_reg] = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
                else if (scan_done)
                begin
                    state_next = ST_RESP;
                    if (op_t'(op_reg) == OP_OPEN && free_found_reg)
                    begin
                        mem_req.we                = 1'b1;
                        mem_req.waddr             = free_slot_reg;
                        mem_req.wdata             = {id_reg, cand_reg};
                        valid_next[free_slot_reg] = 1'b1;
                        next_chan_next            = cand_reg + 1'b1;
                        res_ok_next               = 1'b1;
                        res_chan_next             = cand_reg;
                    end
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_chan_next  = res_chan_reg;
                    out_iface_next = res_iface_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.ok        = out_ok_reg;
    assign rsp.chan_out  = out_chan_reg;
    assign rsp.iface_out = out_iface_reg;

    // table writes only come from a successful open
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == ST_SCAN && free_found_reg
                        && op_t'(op_reg) == OP_OPEN))
        else $error("slot write outside a successful open");

    // a written slot is marked valid on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |=> valid_reg[$past(free_slot_reg)])
        else $error("written slot not marked valid");

    // the channel counter only moves when an open commits
    assert property (@(posedge clk) disable iff (!rst_n)
        (next_chan_reg != $past(next_chan_reg)) |-> $past(mem_req.we))
        else $error("channel counter moved without an open");

    // scan index never runs past the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= CNT_W'(SLOTS)))
        else $error("scan index out of range");

endmodule

`default_nettype wire

// ===== rtl/channel_binding_table.sv =====
// ----------------------------------------------------------------------------
// channel_binding_table
// Binding table from 32-bit interface ids to 8-bit channel numbers.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transfer (op, iface_id, chan); rsp returns
//   exactly one result (ok, chan_out, iface_out) per request, in order.
//   Ops: open, close channel, interface-for-channel, channel-for-interface,
//   remove interface. Unused result fields read zero.
//   Bindings live in a SLOTS-entry RAM; valid marks and the channel counter
//   are flip-flops. Every defined op walks the RAM one slot per cycle.
//   An unknown op skips the walk; lookups and close end it at the first
//   match, remove always walks every slot, and open restarts it from slot 0
//   for each of the P in-use channels it probes before a free one is found;
//   P is at most SLOTS-1, or SLOTS when the table is full and the open is
//   refused.
//   One request is in flight at a time; req.ready is high while idle. A
//   finished response sits in the output register, so the next request is
//   taken while rsp is stalled; the block waits only if a second response
//   is ready before the first is taken.
//   Reset clears all valid marks, the channel counter and the response
//   valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_binding_table
    import cbt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cbt_req_if.sink   req,
    cbt_rsp_if.source rsp
);

    mem_req_t           mem_req;
    logic [ENTRY_W-1:0] mem_rdata;

    cbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    cbt_ram #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W),
        .AW    (SLOT_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== verif/channel_binding_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_binding_table_tb
// Self-checking bench for the channel binding table. A directed opening
// covers empty, full and multi-binding cases, then a long random run mixes
// opens, closes, lookups and removes with random idling on both channels,
// one long response hold-off, and an in-order check of every response
// against a behavioral copy of the table.
// ----------------------------------------------------------------------------

import cbt_pkg::*;

class binding_scoreboard;
    typedef struct packed {
        logic               ok;
        logic [CHAN_W-1:0]  chan;
        logic [IFACE_W-1:0] iface;
    } answer_t;

    bit               bound       [SLOTS];
    bit [IFACE_W-1:0] bound_iface [SLOTS];
    bit [CHAN_W-1:0]  bound_chan  [SLOTS];
    bit [CHAN_W-1:0]  chan_cursor;
    answer_t          expected_answers [$];

    int errors         = 0;
    int opens_granted  = 0;
    int opens_refused  = 0;
    int probe_skips    = 0;
    int cursor_wraps   = 0;
    int lookup_hits    = 0;
    int lookup_misses  = 0;
    int slots_freed    = 0;
    int checked        = 0;

    function int slot_for_chan(bit [CHAN_W-1:0] c);
        for (int i = 0; i < SLOTS; i++)
            if (bound[i] && bound_chan[i] == c)
                return i;
        return -1;
    endfunction

    function int slot_for_iface(bit [IFACE_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (bound[i] && bound_iface[i] == id)
                return i;
        return -1;
    endfunction

    function int random_bound_slot();
        int live [$];
        for (int i = 0; i < SLOTS; i++)
            if (bound[i])
                live.push_back(i);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function void free_binding(int s);
        bound[s]       = 1'b0;
        bound_iface[s] = '0;
        bound_chan[s]  = '0;
        slots_freed++;
    endfunction

    // Apply one accepted request to the table copy and queue its answer.
    function void note_request(logic [OP_W-1:0] op, logic [IFACE_W-1:0] id,
                               logic [CHAN_W-1:0] c);
        answer_t         a;
        int              s;
        int              free_s;
        bit [CHAN_W-1:0] cand;
        a      = '0;
        free_s = -1;
        case (op)
            OP_OPEN:
            begin
                for (s = SLOTS - 1; s >= 0; s--)
                    if (!bound[s])
                        free_s = s;
                if (free_s < 0)
                    opens_refused++;
                else
                begin
                    // probe from the cursor, skipping channels still bound
                    for (int k = 0; k <= SLOTS && !a.ok; k++)
                    begin
                        cand        = chan_cursor;
                        chan_cursor = chan_cursor + 1'b1;
                        if (chan_cursor == '0)
                            cursor_wraps++;
                        if (slot_for_chan(cand) < 0)
                        begin
                            bound[free_s]       = 1'b1;
                            bound_iface[free_s] = id;
                            bound_chan[free_s]  = cand;
                            a.ok                = 1'b1;
                            a.chan              = cand;
                            opens_granted++;
                        end
                        else
                            probe_skips++;
                    end
                end
            end
            OP_CLOSE:
            begin
                s = slot_for_chan(c);
                if (s >= 0)
                    free_binding(s);
            end
            OP_IF_LOOKUP:
            begin
                s = slot_for_chan(c);
                if (s >= 0)
                begin
                    a.ok    = 1'b1;
                    a.iface = bound_iface[s];
                    lookup_hits++;
                end
                else
                    lookup_misses++;
            end
            OP_CH_LOOKUP:
            begin
                s = slot_for_iface(id);
                if (s >= 0)
                begin
                    a.ok   = 1'b1;
                    a.chan = bound_chan[s];
                    lookup_hits++;
                end
                else
                    lookup_misses++;
            end
            OP_REMOVE:
            begin
                for (s = 0; s < SLOTS; s++)
                    if (bound[s] && bound_iface[s] == id)
                        free_binding(s);
            end
            default: ;
        endcase
        expected_answers.push_back(a);
    endfunction

    function void check_response(logic ok, logic [CHAN_W-1:0] chan,
                                 logic [IFACE_W-1:0] iface);
        answer_t want;
        if (expected_answers.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected response: expected none, got ok=%0b chan=%0d iface=%h",
                     $time, ok, chan, iface);
            return;
        end
        want = expected_answers.pop_front();
        checked++;
        if (ok !== want.ok)
        begin
            errors++;
            $display("%0t: ok mismatch: expected %0b, got %0b", $time, want.ok, ok);
        end
        if (chan !== want.chan)
        begin
            errors++;
            $display("%0t: chan_out mismatch: expected %0d, got %0d", $time, want.chan, chan);
        end
        if (iface !== want.iface)
        begin
            errors++;
            $display("%0t: iface_out mismatch: expected %h, got %h", $time, want.iface, iface);
        end
    endfunction
endclass

module channel_binding_table_tb;

    localparam int OP_LAST       = (1 << OP_W) - 1;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int OPEN_WORST    = SLOTS * (SLOTS + 1) + 3;
    localparam int DRAIN_CYCLES  = 2 * OPEN_WORST;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_AT       = 700;
    localparam int HOLD_CYCLES   = 400;

    logic clk;
    logic rst_n;
    int   rsp_count;

    binding_scoreboard sb;

    logic [IFACE_W-1:0] id_pool [8];

    cbt_req_if req_ch ();
    cbt_rsp_if rsp_ch ();

    channel_binding_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Offer one request; it is noted at the edge where it is taken.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [IFACE_W-1:0] id,
                                input logic [CHAN_W-1:0] c, input bit may_idle);
        @(negedge clk);
        while (may_idle && $urandom_range(0, 99) < 30)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.iface_id <= id;
        req_ch.chan     <= c;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(op, id, c);
    endtask

    function automatic logic [IFACE_W-1:0] pick_iface();
        if ($urandom_range(0, 99) < 75)
            return id_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Cycle counter: ends a hung run.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Response side: random stalls, one long hold-off, quiet stretch.
    initial
    begin : rsp_side
        int holdoff_left;
        bit held;
        bit calm;
        rsp_ch.ready = 1'b0;
        holdoff_left = 0;
        held         = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && rsp_count >= HOLD_AT)
            begin
                held         = 1'b1;
                holdoff_left = HOLD_CYCLES;
            end
            calm = (rsp_count >= 900 && rsp_count < 1100);
            if (holdoff_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                holdoff_left--;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_response(rsp_ch.ok, rsp_ch.chan_out, rsp_ch.iface_out);
                rsp_count++;
            end
        end
    end

    initial
    begin
        logic [OP_W-1:0]    op;
        logic [IFACE_W-1:0] id;
        logic [CHAN_W-1:0]  c;
        logic [IFACE_W-1:0] open_ids [SLOTS];
        int                 counted;
        int                 n;
        int                 r;
        int                 s;
        bit                 fill;
        bit                 calm;

        sb              = new();
        rsp_count       = 0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.op       = '0;
        req_ch.iface_id = '0;
        req_ch.chan     = '0;

        id_pool[0] = '0;
        id_pool[1] = '1;
        id_pool[2] = 32'hAAAA_AAAA;
        id_pool[3] = 32'h5555_5555;
        for (int i = 4; i < 8; i++)
            id_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, fill to full, duplicates, remove, reuse.
        send_request(OP_IF_LOOKUP, '0, '0, 1'b1);
        send_request(OP_CH_LOOKUP, '0, '1, 1'b1);
        send_request(OP_CLOSE, '1, '1, 1'b1);
        send_request(OP_REMOVE, '1, '0, 1'b1);
        for (int i = 0; i < SLOTS; i++)
            open_ids[i] = (i == 0) ? '0 : (i < 3) ? '1 : IFACE_W'($urandom);
        for (int i = 0; i < SLOTS; i++)
            send_request(OP_OPEN, open_ids[i], '1, 1'b1);
        send_request(OP_OPEN, 32'h8000_0001, '0, 1'b1);    // table full
        send_request(OP_IF_LOOKUP, '0, CHAN_W'(SLOTS - 1), 1'b1);
        send_request(OP_CH_LOOKUP, '1, '0, 1'b1);          // lowest of two matches
        send_request(OP_REMOVE, '1, '0, 1'b1);             // frees both
        send_request(OP_CH_LOOKUP, '1, '0, 1'b1);
        send_request(OP_CLOSE, '0, '0, 1'b1);
        send_request(OP_CH_LOOKUP, '0, '0, 1'b1);
        send_request(OP_OPEN, 32'h0000_FFFF, '0, 1'b1);
        for (int u = OP_REMOVE + 1; u <= OP_LAST; u++)
            send_request(OP_W'(u), '1, '1, 1'b1);

        // Random: alternate filling and draining phases.
        counted = 0;
        n       = 0;
        while (counted < RANDOM_ITEMS)
        begin
            calm = (n >= 800 && n < 1000);
            fill = ((counted / 150) % 2) == 0;
            r    = $urandom_range(0, 99);
            id   = pick_iface();
            c    = $urandom;
            if (r < (fill ? 45 : 20))
                op = OP_OPEN;
            else if (r < (fill ? 60 : 45))
                op = OP_CLOSE;
            else if (r < (fill ? 74 : 62))
                op = OP_IF_LOOKUP;
            else if (r < (fill ? 88 : 79))
                op = OP_CH_LOOKUP;
            else if (r < 96)
                op = OP_REMOVE;
            else
                op = OP_W'($urandom_range(OP_REMOVE + 1, OP_LAST));

            s = sb.random_bound_slot();
            if (s >= 0 && (op == OP_CLOSE || op == OP_IF_LOOKUP)
                && $urandom_range(0, 99) < 65)
                c = sb.bound_chan[s];
            if (s >= 0 && (op == OP_CH_LOOKUP || op == OP_REMOVE)
                && $urandom_range(0, 99) < 50)
                id = sb.bound_iface[s];

            send_request(op, id, c, !calm);
            if (op <= OP_REMOVE)
                counted++;
            n++;
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d responses, %0d opens granted, %0d refused on a full table",
                 sb.checked, sb.opens_granted, sb.opens_refused);
        $display("     %0d bound channels skipped, %0d counter wraps, %0d/%0d lookups hit/missed",
                 sb.probe_skips, sb.cursor_wraps, sb.lookup_hits, sb.lookup_misses);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cbt_pkg.sv
rtl/cbt_req_if.sv
rtl/cbt_rsp_if.sv
rtl/cbt_ram.sv
rtl/cbt_ctrl.sv
rtl/channel_binding_table.sv
verif/channel_binding_table_tb.sv
